// ===== src/tgn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tgn_pkg;

  localparam int CoordW        = 24;
  localparam int CoordFracBits = 8;
  localparam int OutFracBits   = 14;
  localparam int IdxW          = CoordW - CoordFracBits;
  localparam int PeriodW       = 16;
  localparam int SeedW         = 32;
  localparam int CellW         = 4;
  localparam int NoiseW        = 16;
  localparam int QueueDepth    = 4;

  // Interior arithmetic widths
  localparam int ValW  = 20;
  localparam int ProdW = 40;

  localparam logic [31:0] HashMulX = 32'h6C50B47C;
  localparam logic [31:0] HashMulZ = 32'h9E3779B1;
  localparam logic [31:0] HashMul1 = 32'h85EBCA6B;
  localparam logic [31:0] HashMul2 = 32'hC2B2AE35;

  localparam int QOneInt  = 1 << OutFracBits;
  localparam int QDiagInt = ((7071 << OutFracBits) + 5000) / 10000;

  localparam logic signed [ValW-1:0] QOne     = ValW'(QOneInt);
  localparam logic signed [ValW-1:0] QDiag    = ValW'(QDiagInt);
  localparam logic signed [ValW-1:0] Fade15   = ValW'(15 * QOneInt);
  localparam logic signed [ValW-1:0] Fade10   = ValW'(10 * QOneInt);
  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1 << (OutFracBits - 1));

  typedef struct packed {
    logic [IdxW-1:0]        x0;
    logic [IdxW-1:0]        x1;
    logic [IdxW-1:0]        z0;
    logic [IdxW-1:0]        z1;
    logic [OutFracBits-1:0] dx;
    logic [OutFracBits-1:0] dz;
    logic [SeedW-1:0]       seed;
  } fe_item_t;

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  // Add one half and floor
  function automatic logic signed [ProdW-1:0] round_q(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] w;
    w = v + RndHalf;
    return w >>> OutFracBits;
  endfunction

  // Gradient direction signs for the eight hash codes
  function automatic logic signed [1:0] grad_x(input logic [2:0] k);
    logic signed [1:0] s;
    unique case (k)
      3'd0, 3'd4, 3'd6: s = 2'sd1;
      3'd1, 3'd5, 3'd7: s = -2'sd1;
      default:          s = 2'sd0;
    endcase
    return s;
  endfunction

  function automatic logic signed [1:0] grad_z(input logic [2:0] k);
    logic signed [1:0] s;
    unique case (k)
      3'd2, 3'd4, 3'd5: s = 2'sd1;
      3'd3, 3'd6, 3'd7: s = -2'sd1;
      default:          s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== src/tgn_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tgn_queue #(
  parameter int DEPTH = tgn_pkg::QueueDepth
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  tgn_pkg::fe_item_t   in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tgn_pkg::fe_item_t   out_item_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  tgn_pkg::fe_item_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_ready_o  = (cnt_q != CntW'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store item
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/tgn_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tgn_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire [tgn_pkg::PeriodW-1:0]      tile_period_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire signed [tgn_pkg::CoordW-1:0] x_coord_i,
  input  wire signed [tgn_pkg::CoordW-1:0] z_coord_i,
  input  wire [tgn_pkg::CellW-1:0]        cell_log2_i,
  input  wire [tgn_pkg::SeedW-1:0]        lattice_seed_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output tgn_pkg::fe_item_t               out_item_o
);

  localparam int IdxW = tgn_pkg::IdxW;
  localparam int NStg = IdxW + 1;
  localparam int ShW  = 5;

  typedef struct packed {
    logic [IdxW-1:0]                 mx;
    logic [IdxW-1:0]                 mz;
    logic [IdxW-1:0]                 rx;
    logic [IdxW-1:0]                 rz;
    logic [tgn_pkg::PeriodW-1:0]     per;
    logic                            nx;
    logic                            nz;
    logic [tgn_pkg::OutFracBits-1:0] dx;
    logic [tgn_pkg::OutFracBits-1:0] dz;
    logic [tgn_pkg::SeedW-1:0]       seed;
  } fs_t;

  fs_t  st_q [NStg];
  logic vld_q [NStg + 1];
  logic en;
  tgn_pkg::fe_item_t out_q;

  assign en          = !vld_q[NStg] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg];
  assign out_item_o  = out_q;

  // Split coordinates into cell index and fraction, derive lattice period
  fs_t  st0_d;
  logic [ShW-1:0] fsh, lsh;
  logic signed [tgn_pkg::CoordW-1:0] xs, zs;
  logic [tgn_pkg::CoordW-1:0] xl, zl;
  logic [IdxW-1:0] ix, iz;
  logic [tgn_pkg::PeriodW-1:0] per;

  always_comb begin
    fsh = ShW'(tgn_pkg::CoordFracBits) + ShW'(cell_log2_i);
    lsh = ShW'(tgn_pkg::CoordW) - fsh;
    xs  = x_coord_i >>> fsh;
    zs  = z_coord_i >>> fsh;
    ix  = xs[IdxW-1:0];
    iz  = zs[IdxW-1:0];
    xl  = x_coord_i << lsh;
    zl  = z_coord_i << lsh;
    per = tile_period_i >> cell_log2_i;
    if (per == '0) begin
      per = tgn_pkg::PeriodW'(1);
    end
    st0_d.nx   = ix[IdxW-1];
    st0_d.nz   = iz[IdxW-1];
    st0_d.mx   = ix[IdxW-1] ? (~ix + 1'b1) : ix;
    st0_d.mz   = iz[IdxW-1] ? (~iz + 1'b1) : iz;
    st0_d.rx   = '0;
    st0_d.rz   = '0;
    st0_d.per  = per;
    st0_d.dx   = xl[tgn_pkg::CoordW-1 -: tgn_pkg::OutFracBits];
    st0_d.dz   = zl[tgn_pkg::CoordW-1 -: tgn_pkg::OutFracBits];
    st0_d.seed = lattice_seed_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q[0] <= st0_d;
    end
  end

  // Shift valid flags along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NStg; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= NStg; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Restoring remainder, one dividend bit per stage
  for (genvar k = 0; k < IdxW; k++) begin : g_rem
    fs_t st_d;
    logic [IdxW:0] tx, tz;
    always_comb begin
      st_d = st_q[k];
      tx = {st_q[k].rx, st_q[k].mx[IdxW-1-k]};
      tz = {st_q[k].rz, st_q[k].mz[IdxW-1-k]};
      if (tx >= {1'b0, st_q[k].per}) begin
        tx = tx - {1'b0, st_q[k].per};
      end
      if (tz >= {1'b0, st_q[k].per}) begin
        tz = tz - {1'b0, st_q[k].per};
      end
      st_d.rx = tx[IdxW-1:0];
      st_d.rz = tz[IdxW-1:0];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k+1] <= st_d;
      end
    end
  end

  // Fold negative indices into range and form the next corner
  fs_t fin;
  tgn_pkg::fe_item_t out_d;
  logic [IdxW:0] x1w, z1w;
  always_comb begin
    fin = st_q[IdxW];
    out_d.x0 = (fin.nx && fin.rx != '0) ? fin.per - fin.rx : fin.rx;
    out_d.z0 = (fin.nz && fin.rz != '0) ? fin.per - fin.rz : fin.rz;
    x1w = {1'b0, out_d.x0} + 1'b1;
    z1w = {1'b0, out_d.z0} + 1'b1;
    out_d.x1 = (x1w == {1'b0, fin.per}) ? '0 : x1w[IdxW-1:0];
    out_d.z1 = (z1w == {1'b0, fin.per}) ? '0 : z1w[IdxW-1:0];
    out_d.dx = fin.dx;
    out_d.dz = fin.dz;
    out_d.seed = fin.seed;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/tgn_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tgn_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  tgn_pkg::fe_item_t                in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [tgn_pkg::NoiseW-1:0] noise_value_o
);

  localparam int VW   = tgn_pkg::ValW;
  localparam int PW   = tgn_pkg::ProdW;
  localparam int NStg = 8;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [PW-1:0] prod_t;

  logic vld_q [NStg];
  logic en;

  assign en          = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NStg; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NStg; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Stage 1: corner index products, first fade products
  logic [31:0] xm0_q, xm1_q, zm0_q, zm1_q, seed1_q;
  val_t  du1_q, dv1_q;
  prod_t pau_q, pav_q, p2u_q, p2v_q;
  val_t  tu, tv;

  always_comb begin
    tu = VW'(in_item_i.dx);
    tv = VW'(in_item_i.dz);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xm0_q   <= tgn_pkg::mul32(32'(in_item_i.x0), tgn_pkg::HashMulX);
      xm1_q   <= tgn_pkg::mul32(32'(in_item_i.x1), tgn_pkg::HashMulX);
      zm0_q   <= tgn_pkg::mul32(32'(in_item_i.z0), tgn_pkg::HashMulZ);
      zm1_q   <= tgn_pkg::mul32(32'(in_item_i.z1), tgn_pkg::HashMulZ);
      seed1_q <= in_item_i.seed;
      du1_q   <= tu;
      dv1_q   <= tv;
      pau_q   <= tu * ((tu <<< 2) + (tu <<< 1) - tgn_pkg::Fade15);
      pav_q   <= tv * ((tv <<< 2) + (tv <<< 1) - tgn_pkg::Fade15);
      p2u_q   <= tu * tu;
      p2v_q   <= tv * tv;
    end
  end

  // Stage 2: mix corner hashes, cube term, diagonal products
  logic [31:0] h2_q [4];
  val_t  du2_q, dv2_q, bu2_q, bv2_q;
  prod_t p3u_q, p3v_q;
  prod_t pdx0_q, pdx1_q, pdz0_q, pdz1_q;
  logic [31:0] xmc [4];
  logic [31:0] zmc [4];
  logic [31:0] hm [4];
  val_t t2u, t2v;

  always_comb begin
    xmc[0] = xm0_q; zmc[0] = zm0_q;
    xmc[1] = xm1_q; zmc[1] = zm0_q;
    xmc[2] = xm0_q; zmc[2] = zm1_q;
    xmc[3] = xm1_q; zmc[3] = zm1_q;
    for (int c = 0; c < 4; c++) begin
      hm[c] = seed1_q ^ xmc[c];
      hm[c] = {hm[c][18:0], hm[c][31:19]} ^ zmc[c];
      hm[c] = hm[c] ^ (hm[c] >> 16);
    end
    t2u = VW'(tgn_pkg::round_q(p2u_q));
    t2v = VW'(tgn_pkg::round_q(p2v_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        h2_q[c] <= tgn_pkg::mul32(hm[c], tgn_pkg::HashMul1);
      end
      du2_q  <= du1_q;
      dv2_q  <= dv1_q;
      bu2_q  <= VW'(tgn_pkg::round_q(pau_q)) + tgn_pkg::Fade10;
      bv2_q  <= VW'(tgn_pkg::round_q(pav_q)) + tgn_pkg::Fade10;
      p3u_q  <= t2u * du1_q;
      p3v_q  <= t2v * dv1_q;
      pdx0_q <= du1_q * tgn_pkg::QDiag;
      pdx1_q <= (du1_q - tgn_pkg::QOne) * tgn_pkg::QDiag;
      pdz0_q <= dv1_q * tgn_pkg::QDiag;
      pdz1_q <= (dv1_q - tgn_pkg::QOne) * tgn_pkg::QDiag;
    end
  end

  // Stage 3: second hash multiply, fade product
  logic [31:0] h3_q [4];
  val_t  du3_q, dv3_q;
  prod_t pfu_q, pfv_q;
  prod_t pdx0_3q, pdx1_3q, pdz0_3q, pdz1_3q;
  logic [31:0] hn [4];
  val_t t3u, t3v;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hn[c] = h2_q[c] ^ (h2_q[c] >> 13);
    end
    t3u = VW'(tgn_pkg::round_q(p3u_q));
    t3v = VW'(tgn_pkg::round_q(p3v_q));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        h3_q[c] <= tgn_pkg::mul32(hn[c], tgn_pkg::HashMul2);
      end
      du3_q   <= du2_q;
      dv3_q   <= dv2_q;
      pfu_q   <= t3u * bu2_q;
      pfv_q   <= t3v * bv2_q;
      pdx0_3q <= pdx0_q;
      pdx1_3q <= pdx1_q;
      pdz0_3q <= pdz0_q;
      pdz1_3q <= pdz1_q;
    end
  end

  // Stage 4: pick gradients, dot products, clamp fade
  val_t d_q [4];
  val_t u4_q, v4_q;
  val_t  oxc [4];
  val_t  ozc [4];
  prod_t pxc [4];
  prod_t pzc [4];
  val_t  dd [4];
  val_t  fu, fv;
  logic [31:0] hf;
  logic [2:0]  kc;
  logic signed [1:0] sx, sz;
  prod_t bx, bz, tx, tz;

  function automatic val_t clamp_fade(input prod_t p);
    prod_t r;
    val_t  o;
    r = tgn_pkg::round_q(p);
    if (r < 0) begin
      o = '0;
    end else if (r > PW'(tgn_pkg::QOne)) begin
      o = tgn_pkg::QOne;
    end else begin
      o = r[VW-1:0];
    end
    return o;
  endfunction

  always_comb begin
    oxc[0] = du3_q;                  ozc[0] = dv3_q;
    oxc[1] = du3_q - tgn_pkg::QOne;  ozc[1] = dv3_q;
    oxc[2] = du3_q;                  ozc[2] = dv3_q - tgn_pkg::QOne;
    oxc[3] = du3_q - tgn_pkg::QOne;  ozc[3] = dv3_q - tgn_pkg::QOne;
    pxc[0] = pdx0_3q; pzc[0] = pdz0_3q;
    pxc[1] = pdx1_3q; pzc[1] = pdz0_3q;
    pxc[2] = pdx0_3q; pzc[2] = pdz1_3q;
    pxc[3] = pdx1_3q; pzc[3] = pdz1_3q;
    hf = '0; kc = '0; sx = '0; sz = '0;
    bx = '0; bz = '0; tx = '0; tz = '0;
    for (int c = 0; c < 4; c++) begin
      hf = h3_q[c] ^ (h3_q[c] >> 16);
      kc = hf[2:0];
      sx = tgn_pkg::grad_x(kc);
      sz = tgn_pkg::grad_z(kc);
      bx = kc[2] ? pxc[c] : (PW'(oxc[c]) <<< tgn_pkg::OutFracBits);
      bz = kc[2] ? pzc[c] : (PW'(ozc[c]) <<< tgn_pkg::OutFracBits);
      tx = (sx == 2'sd0) ? '0 : ((sx == 2'sd1) ? bx : -bx);
      tz = (sz == 2'sd0) ? '0 : ((sz == 2'sd1) ? bz : -bz);
      dd[c] = VW'(tgn_pkg::round_q(tx + tz));
    end
    fu = clamp_fade(pfu_q);
    fv = clamp_fade(pfv_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        d_q[c] <= dd[c];
      end
      u4_q <= fu;
      v4_q <= fv;
    end
  end

  // Stage 5: interpolation products along x
  prod_t pa5_q, pb5_q;
  val_t  d00_5q, d01_5q, v5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa5_q  <= u4_q * (d_q[1] - d_q[0]);
      pb5_q  <= u4_q * (d_q[3] - d_q[2]);
      d00_5q <= d_q[0];
      d01_5q <= d_q[2];
      v5_q   <= v4_q;
    end
  end

  // Stage 6: finish x interpolation
  val_t a6_q, b6_q, v6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a6_q <= d00_5q + VW'(tgn_pkg::round_q(pa5_q));
      b6_q <= d01_5q + VW'(tgn_pkg::round_q(pb5_q));
      v6_q <= v5_q;
    end
  end

  // Stage 7: interpolation product along z
  prod_t pr7_q;
  val_t  a7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr7_q <= v6_q * (b6_q - a6_q);
      a7_q  <= a6_q;
    end
  end

  // Stage 8: finish and saturate
  val_t r8;
  logic signed [tgn_pkg::NoiseW-1:0] sat, noise_q;

  always_comb begin
    r8 = a7_q + VW'(tgn_pkg::round_q(pr7_q));
    if (r8 > VW'(32767)) begin
      sat = 16'sh7FFF;
    end else if (r8 < -VW'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = r8[tgn_pkg::NoiseW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      noise_q <= sat;
    end
  end

  assign noise_value_o = noise_q;

endmodule
`default_nettype wire

// ===== src/tileable_gradient_noise_core.sv =====
// Throughput: one item per cycle unless the output stalls; the front runs a
// 16-stage restoring remainder (one index bit per stage) for the lattice wrap,
// the back an 8-stage hash, fade and interpolation pipeline, with a 4-entry
// queue between.
// Reset: rst_ni clears all valid flags and queue state; tile_period returns to 1024.
`timescale 1ns / 1ps
`default_nettype none
module tileable_gradient_noise_core #(
  parameter int QUEUE_DEPTH = tgn_pkg::QueueDepth
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [tgn_pkg::PeriodW-1:0]        cfg_data_i,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire signed [tgn_pkg::CoordW-1:0]  x_coord_i,
  input  wire signed [tgn_pkg::CoordW-1:0]  z_coord_i,
  input  wire [tgn_pkg::CellW-1:0]          cell_log2_i,
  input  wire [tgn_pkg::SeedW-1:0]          lattice_seed_i,
  output logic                              noise_valid_o,
  input  wire                               noise_ready_i,
  output logic signed [tgn_pkg::NoiseW-1:0] noise_value_o
);

  logic [tgn_pkg::PeriodW-1:0] tile_period_q;
  logic fe_valid, fe_ready, q_valid, q_ready;
  tgn_pkg::fe_item_t fe_item, q_item;

  // Hold the tile period register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_period_q <= tgn_pkg::PeriodW'(1024);
    end else if (cfg_valid_i) begin
      tile_period_q <= cfg_data_i;
    end
  end

  tgn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tile_period_i  (tile_period_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .x_coord_i      (x_coord_i),
    .z_coord_i      (z_coord_i),
    .cell_log2_i    (cell_log2_i),
    .lattice_seed_i (lattice_seed_i),
    .out_valid_o    (fe_valid),
    .out_ready_i    (fe_ready),
    .out_item_o     (fe_item)
  );

  tgn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fe_valid),
    .in_ready_o  (fe_ready),
    .in_item_i   (fe_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_item_o  (q_item)
  );

  tgn_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (q_valid),
    .in_ready_o    (q_ready),
    .in_item_i     (q_item),
    .out_valid_o   (noise_valid_o),
    .out_ready_i   (noise_ready_i),
    .noise_value_o (noise_value_o)
  );

  // A front item refused by a full queue must wait unchanged
  a_front_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fe_valid && !fe_ready) |=> (fe_valid && $stable(fe_item)))
    else $error("front item changed while queue was full");

  // A queued item not taken by the back stays at the queue head
  a_queue_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !q_ready) |=> (q_valid && $stable(q_item)))
    else $error("queue head changed while back was stalled");

  // Nothing reaches the output right after reset
  a_reset_empty : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !noise_valid_o)
    else $error("result valid straight out of reset");

endmodule
`default_nettype wire
